### hw/rtl/bfdp_pkg.sv
package bfdp_pkg;

  localparam int DEPTH            = 16;
  localparam int SLOT_BYTES       = 8;
  localparam int DROP_COUNT_WIDTH = 32;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = PTR_W + 1;
  localparam int DATA_W = 8 * SLOT_BYTES;
  localparam int LEN_W  = 4;
  localparam int META_W = 64;
  localparam int CFG_W  = 5;
  localparam int CAP_W  = 5;

  localparam logic CFG_CAPACITY   = 1'b0;
  localparam logic CFG_SLOT_BYTES = 1'b1;

  localparam logic [1:0] POL_BLOCK       = 2'd0;
  localparam logic [1:0] POL_DROP_NEWEST = 2'd1;
  localparam logic [1:0] POL_DROP_OLDEST = 2'd2;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_DROPPED       = 3'd1,
    ST_ERROR         = 3'd2,
    ST_WOULD_BLOCK   = 3'd3,
    ST_END_OF_STREAM = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPLY
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [1:0]          policy;
    logic [DATA_W-1:0]   payload;
    logic [LEN_W-1:0]    byte_length;
    logic [META_W-1:0]   meta_word;
    logic                meta_present;
  } cmd_t;

  typedef struct packed {
    status_t                     status;
    logic [DATA_W-1:0]           out_payload;
    logic [LEN_W-1:0]            out_length;
    logic [META_W-1:0]           out_meta;
    logic                        out_meta_present;
    logic [CNT_W-1:0]            fill_count;
    logic [CNT_W-1:0]            peak_fill;
    logic [DROP_COUNT_WIDTH-1:0] drops_total;
    logic                        writer_done;
  } res_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] payload;
    logic [LEN_W-1:0]  length;
    logic [META_W-1:0] meta;
    logic              meta_flag;
  } slot_t;

  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    for (int b = 0; b < SLOT_BYTES; b++) begin
      m[8*b +: 8] = (len > LEN_W'(b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] sum;
    sum = {1'b0, p} + CNT_W'(1);
    return (sum >= cap) ? '0 : sum[PTR_W-1:0];
  endfunction

endpackage

### hw/rtl/bfdp_ctrl.sv
module bfdp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output bfdp_pkg::ctl_t  ctl
);

  bfdp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfdp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bfdp_pkg::S_IDLE: begin
        if (start) state_next = bfdp_pkg::S_EXEC;
      end
      bfdp_pkg::S_EXEC: begin
        state_next = bfdp_pkg::S_REPLY;
      end
      bfdp_pkg::S_REPLY: begin
        state_next = start ? bfdp_pkg::S_EXEC : bfdp_pkg::S_IDLE;
      end
      default: begin
        state_next = bfdp_pkg::S_IDLE;
      end
    endcase
  end

  // The result is presented while a new beat may already be taken.
  always_comb begin
    busy     = (state == bfdp_pkg::S_EXEC);
    done     = (state == bfdp_pkg::S_REPLY);
    ctl.load = start && (state != bfdp_pkg::S_EXEC);
    ctl.exec = (state == bfdp_pkg::S_EXEC);
  end

endmodule

### hw/rtl/bfdp_datapath.sv
module bfdp_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  bfdp_pkg::ctl_t              ctl,
  input  bfdp_pkg::cmd_t              cmd,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bfdp_pkg::CFG_W-1:0]  cfg_data,
  output bfdp_pkg::res_t              result
);

  bfdp_pkg::slot_t mem [bfdp_pkg::DEPTH];
  bfdp_pkg::slot_t rd_slot;
  bfdp_pkg::slot_t wr_slot;
  bfdp_pkg::cmd_t  cmd_q;

  logic [bfdp_pkg::PTR_W-1:0]            wr_ptr;
  logic [bfdp_pkg::PTR_W-1:0]            rd_ptr;
  logic [bfdp_pkg::CNT_W-1:0]            occupancy;
  logic [bfdp_pkg::CNT_W-1:0]            occupancy_next;
  logic [bfdp_pkg::CNT_W-1:0]            peak;
  logic [bfdp_pkg::CNT_W-1:0]            capacity;
  logic [bfdp_pkg::LEN_W-1:0]            slot_bytes;
  logic [bfdp_pkg::DROP_COUNT_WIDTH-1:0] drops;
  logic                                  closed;
  logic                                  stopped;
  bfdp_pkg::status_t                     status_q;
  bfdp_pkg::status_t                     status_next;
  logic                                  pop_ok;

  logic full;
  logic do_write;
  logic do_evict;
  logic do_pop;
  logic do_drop;

  logic [bfdp_pkg::CAP_W-1:0] cap_raw;
  logic [bfdp_pkg::CNT_W-1:0] cap_clamped;
  logic [bfdp_pkg::LEN_W-1:0] sb_raw;
  logic [bfdp_pkg::LEN_W-1:0] sb_clamped;

  assign full = (occupancy >= capacity);

  always_comb begin
    status_next = bfdp_pkg::ST_OK;
    do_write    = 1'b0;
    do_evict    = 1'b0;
    do_pop      = 1'b0;
    do_drop     = 1'b0;
    unique case (cmd_q.action)
      bfdp_pkg::ACT_PUSH: begin
        // The length check and the stopped check share one condition; either gives an error.
        priority if ((cmd_q.byte_length > slot_bytes) || stopped) begin
          status_next = bfdp_pkg::ST_ERROR;
        end else if (full && (cmd_q.policy != bfdp_pkg::POL_DROP_NEWEST)
                          && (cmd_q.policy != bfdp_pkg::POL_DROP_OLDEST)) begin
          status_next = bfdp_pkg::ST_WOULD_BLOCK;
        end else if (full && (cmd_q.policy == bfdp_pkg::POL_DROP_NEWEST)) begin
          status_next = bfdp_pkg::ST_DROPPED;
          do_drop     = 1'b1;
        end else begin
          do_write = 1'b1;
          do_evict = full;
          do_drop  = full;
        end
      end
      bfdp_pkg::ACT_POP: begin
        priority if (stopped) begin
          status_next = bfdp_pkg::ST_ERROR;
        end else if (occupancy == '0) begin
          status_next = closed ? bfdp_pkg::ST_END_OF_STREAM : bfdp_pkg::ST_WOULD_BLOCK;
        end else begin
          do_pop = 1'b1;
        end
      end
      bfdp_pkg::ACT_CLOSE,
      bfdp_pkg::ACT_STOP: begin
        status_next = bfdp_pkg::ST_OK;
      end
      default: begin
        status_next = bfdp_pkg::ST_OK;
      end
    endcase
  end

  // Evicting the oldest entry and storing the new one leave the fill unchanged.
  always_comb begin
    occupancy_next = occupancy;
    if (do_write && !do_evict) occupancy_next = occupancy + bfdp_pkg::CNT_W'(1);
    if (do_pop)                occupancy_next = occupancy - bfdp_pkg::CNT_W'(1);
  end

  always_comb begin
    wr_slot.payload   = cmd_q.payload & bfdp_pkg::byte_mask(cmd_q.byte_length);
    wr_slot.length    = cmd_q.byte_length;
    wr_slot.meta      = cmd_q.meta_present ? cmd_q.meta_word : '0;
    wr_slot.meta_flag = cmd_q.meta_present;
  end

  always_comb begin
    cap_raw = cfg_data[bfdp_pkg::CAP_W-1:0];
    priority if (cap_raw == '0) begin
      cap_clamped = bfdp_pkg::CNT_W'(1);
    end else if (int'(cap_raw) > bfdp_pkg::DEPTH) begin
      cap_clamped = bfdp_pkg::CNT_W'(bfdp_pkg::DEPTH);
    end else begin
      cap_clamped = bfdp_pkg::CNT_W'(cap_raw);
    end
    sb_raw = cfg_data[bfdp_pkg::LEN_W-1:0];
    priority if (sb_raw == '0) begin
      sb_clamped = bfdp_pkg::LEN_W'(1);
    end else if (int'(sb_raw) > bfdp_pkg::SLOT_BYTES) begin
      sb_clamped = bfdp_pkg::LEN_W'(bfdp_pkg::SLOT_BYTES);
    end else begin
      sb_clamped = sb_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && do_write) begin
      mem[wr_ptr] <= wr_slot;
    end
    if (ctl.exec) begin
      rd_slot <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      occupancy  <= '0;
      peak       <= '0;
      drops      <= '0;
      closed     <= 1'b0;
      stopped    <= 1'b0;
      capacity   <= bfdp_pkg::CNT_W'(bfdp_pkg::DEPTH);
      slot_bytes <= bfdp_pkg::LEN_W'(bfdp_pkg::SLOT_BYTES);
      status_q   <= bfdp_pkg::ST_OK;
      pop_ok     <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == bfdp_pkg::CFG_CAPACITY) begin
        // A new capacity empties the queue; statistics and flags survive.
        capacity  <= cap_clamped;
        wr_ptr    <= '0;
        rd_ptr    <= '0;
        occupancy <= '0;
      end else begin
        slot_bytes <= sb_clamped;
      end
    end else if (ctl.exec) begin
      status_q  <= status_next;
      pop_ok    <= do_pop;
      occupancy <= occupancy_next;
      if (do_write) wr_ptr <= bfdp_pkg::next_ptr(wr_ptr, capacity);
      if (do_evict || do_pop) rd_ptr <= bfdp_pkg::next_ptr(rd_ptr, capacity);
      if (occupancy_next > peak) peak <= occupancy_next;
      if (do_drop && (drops != '1)) drops <= drops + bfdp_pkg::DROP_COUNT_WIDTH'(1);
      if (cmd_q.action == bfdp_pkg::ACT_CLOSE) closed <= 1'b1;
      if (cmd_q.action == bfdp_pkg::ACT_STOP) stopped <= 1'b1;
    end
  end

  always_comb begin
    result.status           = status_q;
    result.out_payload      = pop_ok ? rd_slot.payload : '0;
    result.out_length       = pop_ok ? rd_slot.length : '0;
    result.out_meta         = pop_ok ? rd_slot.meta : '0;
    result.out_meta_present = pop_ok && rd_slot.meta_flag;
    result.fill_count       = occupancy;
    result.peak_fill        = peak;
    result.drops_total      = drops;
    result.writer_done      = closed;
  end

endmodule

### hw/rtl/bounded_fifo_with_drop_policy_top.sv
// A beat accepted by start is registered, executed in the execute state, and has its result on
// the result port in the reply state, marked by done for that single cycle.
// No new beat is accepted while busy is high in the execute state.
// A new beat may be accepted in the same cycle that done is high.
// Reset (rst, synchronous) empties the queue, clears statistics and flags, and restores
// full capacity and full slot size; slot contents are not cleared.
module bounded_fifo_with_drop_policy_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  bfdp_pkg::cmd_t              cmd,
  output logic                        done,
  output bfdp_pkg::res_t              result,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bfdp_pkg::CFG_W-1:0]  cfg_data
);

  bfdp_pkg::ctl_t ctl;

  bfdp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  bfdp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

### hw/rtl/bfdp_checker.sv
module bfdp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input bfdp_pkg::res_t              result
);

  // Every accepted beat answers with done once its execute state is over.
  a_answer_time: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted beat did not answer on time");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_peak_bounds_fill: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.peak_fill >= result.fill_count))
    else $error("peak fill below current fill");

  // Only a successful pop carries data.
  a_data_only_on_pop: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != bfdp_pkg::ST_OK)) |->
      ((result.out_payload == '0) && (result.out_length == '0) &&
       (result.out_meta == '0) && !result.out_meta_present))
    else $error("data shown on a failed beat");

endmodule

bind bounded_fifo_with_drop_policy_top bfdp_checker u_bfdp_checker (.*);
